>>> rtl/sdf_pkg.sv
// Shared types, constants and the CRC7 byte update for the SD SPI command framer.
package sdf_pkg;

  localparam logic [7:0] FLUSH_BYTE = 8'hFF;
  localparam logic [6:0] CRC7_POLY  = 7'h09;

  // Position of a byte within the eight-byte command frame
  typedef enum logic [2:0] {
    POS_FLUSH = 3'd0,
    POS_CMD   = 3'd1,
    POS_ARG3  = 3'd2,
    POS_ARG2  = 3'd3,
    POS_ARG1  = 3'd4,
    POS_ARG0  = 3'd5,
    POS_CRC   = 3'd6,
    POS_END   = 3'd7
  } pos_t;

  typedef struct packed {
    logic [7:0]  command_byte;
    logic [31:0] argument;
  } cmd_t;

  // Advance the CRC7 register over one byte, MSB first
  function automatic logic [6:0] crc7_byte(input logic [6:0] crc_in, input logic [7:0] data);
    logic [6:0] crc;
    logic       fb;
    crc = crc_in;
    for (int k = 7; k >= 0; k--) begin
      fb  = data[k] ^ crc[6];
      crc = {crc[5:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC7_POLY;
      end
    end
    return crc;
  endfunction

endpackage

>>> rtl/sdf_if.sv
// Valid/ready channel interfaces for command words and frame byte words.
interface sdf_cmd_if;
  logic        valid;
  logic        ready;
  logic [7:0]  command_byte;
  logic [31:0] argument;

  modport source (output valid, output command_byte, output argument, input ready);
  modport sink   (input valid, input command_byte, input argument, output ready);
endinterface

interface sdf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink   (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/sdf_in_buf.sv
// Input holding register: takes the next command word while a frame is still going out.
module sdf_in_buf (
  input  logic clk,
  input  logic rst_n,
  sdf_cmd_if.sink   in_cmd,
  sdf_cmd_if.source hold
);
  import sdf_pkg::*;

  logic buf_valid_r;
  logic buf_valid_nxt;
  cmd_t buf_r;
  cmd_t buf_nxt;

  // Accept when empty or when the word is handed on in this cycle
  assign in_cmd.ready = !buf_valid_r || hold.ready;

  assign hold.valid        = buf_valid_r;
  assign hold.command_byte = buf_r.command_byte;
  assign hold.argument     = buf_r.argument;

  // Fill, hold or drain the buffer
  always_comb begin
    buf_valid_nxt = buf_valid_r;
    buf_nxt       = buf_r;
    if (in_cmd.valid && in_cmd.ready) begin
      buf_valid_nxt        = 1'b1;
      buf_nxt.command_byte = in_cmd.command_byte;
      buf_nxt.argument     = in_cmd.argument;
    end else if (hold.ready) begin
      buf_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
  end

endmodule

>>> rtl/sdf_ser.sv
// Frame serializer: emits flush, command, argument, CRC and end bytes, updating CRC over each data byte.
module sdf_ser (
  input  logic clk,
  input  logic rst_n,
  sdf_cmd_if.sink    hold,
  sdf_byte_if.source out_frame
);
  import sdf_pkg::*;

  logic       busy_r, busy_nxt;
  pos_t       pos_r, pos_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [6:0] crc_r, crc_nxt;
  logic [7:0] cur_byte;
  logic       is_data;
  logic       load;

  // Load a new command when idle or as the end byte leaves
  assign hold.ready = !busy_r || (pos_r == POS_END && out_frame.ready);
  assign load       = hold.valid && hold.ready;

  // Select the byte at the current frame position
  always_comb begin
    cur_byte = FLUSH_BYTE;
    is_data  = 1'b0;
    unique case (pos_r)
      POS_FLUSH: cur_byte = FLUSH_BYTE;
      POS_CMD:  begin cur_byte = cmd_r.command_byte;   is_data = 1'b1; end
      POS_ARG3: begin cur_byte = cmd_r.argument[31:24]; is_data = 1'b1; end
      POS_ARG2: begin cur_byte = cmd_r.argument[23:16]; is_data = 1'b1; end
      POS_ARG1: begin cur_byte = cmd_r.argument[15:8];  is_data = 1'b1; end
      POS_ARG0: begin cur_byte = cmd_r.argument[7:0];   is_data = 1'b1; end
      POS_CRC:   cur_byte = {crc_r, 1'b1};
      POS_END:   cur_byte = FLUSH_BYTE;
      default:   cur_byte = FLUSH_BYTE;
    endcase
  end

  assign out_frame.valid    = busy_r;
  assign out_frame.out_byte = cur_byte;
  assign out_frame.last     = (pos_r == POS_END);

  // Advance through the frame on each taken byte
  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    cmd_nxt  = cmd_r;
    crc_nxt  = crc_r;
    if (load) begin
      busy_nxt             = 1'b1;
      pos_nxt              = POS_FLUSH;
      cmd_nxt.command_byte = hold.command_byte;
      cmd_nxt.argument     = hold.argument;
      crc_nxt              = '0;
    end else if (busy_r && out_frame.ready) begin
      if (pos_r == POS_END) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = pos_t'(pos_r + 3'd1);
      end
      if (is_data) begin
        crc_nxt = crc7_byte(crc_r, cur_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= POS_FLUSH;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    crc_r <= crc_nxt;
  end

endmodule

>>> rtl/sd_spi_command_framer_top.sv
// SD SPI-mode command framer: one command word in, an eight-byte frame out. Each command
// gives 0xFF, the command byte, four argument bytes MSB first, CRC7 byte with end bit, and
// a closing 0xFF flagged last. Output runs one byte per cycle while out_frame.ready is high,
// and the serializer's byte position counter steps through the eight bytes of each frame.
// A one-word holding register takes the next command while the current frame goes out, and
// frames follow each other with no gap. The CRC is built one byte per cycle as the data
// bytes are sent. Nothing is kept from one command to the next.
module sd_spi_command_framer_top (
  input  logic clk,
  input  logic rst_n,
  sdf_cmd_if.sink    in_cmd,
  sdf_byte_if.source out_frame
);
  import sdf_pkg::*;

  sdf_cmd_if hold ();

  sdf_in_buf u_in_buf (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (in_cmd),
    .hold   (hold.source)
  );

  sdf_ser u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .hold      (hold.sink),
    .out_frame (out_frame)
  );

  // End byte of a frame is always the flush pattern
  a_last_is_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame.valid && out_frame.last |-> out_frame.out_byte == FLUSH_BYTE)
    else $error("last word is not 0xFF");

  // After a frame ends the next word, if any, opens with a flush byte
  a_frame_opens_flush: assert property (@(posedge clk) disable iff (!rst_n)
    out_frame.valid && out_frame.ready && out_frame.last
      |=> !out_frame.valid || (out_frame.out_byte == FLUSH_BYTE && !out_frame.last))
    else $error("frame does not open with flush byte");

  // A new command enters the serializer mid-stream only as the end byte leaves
  a_load_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    hold.valid && hold.ready && out_frame.valid |-> out_frame.ready && out_frame.last)
    else $error("command loaded in the middle of a frame");

endmodule

>>> test/tb_top.sv
// Testbench for the SD SPI-mode command framer: random and directed commands, byte-level checks.
`timescale 1ns / 1ps

module tb_top;
  import sdf_pkg::*;

  // One expected frame byte, tagged with its place in the frame
  typedef struct {
    pos_t       pos;
    logic [7:0] data;
    logic       last;
  } frame_byte_t;

  logic clk;
  logic rst_n;

  sdf_cmd_if  cmd_ch ();
  sdf_byte_if frame_ch ();

  sd_spi_command_framer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (cmd_ch),
    .out_frame (frame_ch)
  );

  frame_byte_t frame_byte_q[$];
  int          mismatch_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          hold_off_left = 0;

  // Drive every input to a known value from time zero
  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.command_byte = '0;
    cmd_ch.argument     = '0;
    frame_ch.ready      = 1'b0;
  end

  always #5 clk = ~clk;

  // Overall time limit
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  // CRC7, x^7 + x^3 + 1, over the command byte and argument, MSB first
  function automatic logic [6:0] crc7_over(input logic [39:0] bits);
    logic [6:0] r;
    logic       fb;
    r = '0;
    for (int i = 39; i >= 0; i--) begin
      fb = bits[i] ^ r[6];
      r  = {r[5:3], r[2] ^ fb, r[1:0], fb};
    end
    return r;
  endfunction

  // Queue the eight bytes that one command word must produce
  task automatic queue_frame(input logic [7:0] c, input logic [31:0] a);
    logic [7:0] crc_byte;
    crc_byte = {crc7_over({c, a}), 1'b1};
    frame_byte_q.push_back('{POS_FLUSH, FLUSH_BYTE, 1'b0});
    frame_byte_q.push_back('{POS_CMD,   c,          1'b0});
    frame_byte_q.push_back('{POS_ARG3,  a[31:24],   1'b0});
    frame_byte_q.push_back('{POS_ARG2,  a[23:16],   1'b0});
    frame_byte_q.push_back('{POS_ARG1,  a[15:8],    1'b0});
    frame_byte_q.push_back('{POS_ARG0,  a[7:0],     1'b0});
    frame_byte_q.push_back('{POS_CRC,   crc_byte,   1'b0});
    frame_byte_q.push_back('{POS_END,   FLUSH_BYTE, 1'b1});
  endtask

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Predict on each accepted command word, then check each accepted byte word
  always @(posedge clk) begin : monitor
    frame_byte_t exp_b;
    if (rst_n) begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        queue_frame(cmd_ch.command_byte, cmd_ch.argument);
      end
      if (frame_ch.valid && frame_ch.ready) begin
        if (frame_byte_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte word %02h last=%0b",
                                    frame_ch.out_byte, frame_ch.last));
        end else begin
          exp_b = frame_byte_q.pop_front();
          if (frame_ch.out_byte !== exp_b.data) begin
            report_mismatch($sformatf("%s byte got %02h expected %02h",
                                      exp_b.pos.name(), frame_ch.out_byte, exp_b.data));
          end
          if (frame_ch.last !== exp_b.last) begin
            report_mismatch($sformatf("%s last got %0b expected %0b",
                                      exp_b.pos.name(), frame_ch.last, exp_b.last));
          end
        end
      end
    end
  end

  // Receiver: hold off while a long stall is pending, else stall at random
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      frame_ch.ready = 1'b0;
      hold_off_left  = hold_off_left - 1;
    end else begin
      frame_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Offer one command word, idling first at random, and wait until it is taken
  task automatic send_command(input logic [7:0] c, input logic [31:0] a);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_ch.valid        = 1'b0;
      cmd_ch.command_byte = 8'($urandom);
      cmd_ch.argument     = $urandom;
      @(negedge clk);
    end
    cmd_ch.valid        = 1'b1;
    cmd_ch.command_byte = c;
    cmd_ch.argument     = a;
    do @(posedge clk); while (!cmd_ch.ready);
  endtask

  // Mostly well-formed commands, some raw bytes; arguments favor the extremes now and then
  task automatic send_random_commands(input int count);
    logic [7:0]  c;
    logic [31:0] a;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(3) != 0) c = {2'b01, 6'($urandom)};
      else                        c = 8'($urandom);
      case ($urandom_range(7))
        0:       a = '0;
        1:       a = '1;
        2:       a = 32'h1 << $urandom_range(31);
        default: a = $urandom;
      endcase
      send_command(c, a);
    end
  endtask

  task automatic test_directed();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_command(8'h40, 32'h0000_0000);
    send_command(8'h48, 32'h0000_01AA);
    send_command(8'h77, 32'h0000_0000);
    send_command(8'h69, 32'h4000_0000);
    send_command(8'h50, 32'h0000_0200);
    send_command(8'h51, 32'h0000_0000);
    send_command(8'h7A, 32'h0000_0000);
    send_command(8'h00, 32'h0000_0000);
    send_command(8'hFF, 32'hFFFF_FFFF);
    send_command(8'h00, 32'hFFFF_FFFF);
    send_command(8'hFF, 32'h0000_0000);
    send_command(8'h3F, 32'h8000_0000);
    send_command(8'h80, 32'h0000_0001);
    send_command(8'hC0, 32'h7FFF_FFFF);
    send_command(8'h7F, 32'hAAAA_AAAA);
    send_command(8'h55, 32'h5555_5555);
    send_command(8'hAA, 32'h0123_4567);
    send_command(8'h01, 32'hFEDC_BA98);
    send_command(8'h40, 32'h0000_0000);
  endtask

  task automatic test_random_no_idle();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_random_commands(90);
  endtask

  task automatic test_random_sender_idle();
    sender_idle_pct    = 47;
    receiver_stall_pct = 0;
    send_random_commands(90);
  endtask

  task automatic test_random_receiver_stall();
    sender_idle_pct    = 0;
    receiver_stall_pct = 47;
    send_random_commands(90);
  endtask

  task automatic test_random_both_idle();
    sender_idle_pct    = 10;
    receiver_stall_pct = 10;
    send_random_commands(80);
  endtask

  // Hold the receiver off long enough that the framer fills and stalls its input
  task automatic test_backpressure();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    @(negedge clk);
    cmd_ch.valid  = 1'b0;
    hold_off_left = 300;
    send_random_commands(12);
  endtask

  initial begin : main
    int wait_cycles;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_backpressure();
    test_random_receiver_stall();
    test_random_both_idle();

    // Drop valid, let the receiver run freely, and drain what is still expected
    @(negedge clk);
    cmd_ch.valid       = 1'b0;
    receiver_stall_pct = 0;
    wait_cycles        = 0;
    while (frame_byte_q.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    if (frame_byte_q.size() != 0) begin
      report_mismatch($sformatf("%0d frame bytes never arrived", frame_byte_q.size()));
    end
    repeat (20) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/sdf_pkg.sv
rtl/sdf_if.sv
rtl/sdf_in_buf.sv
rtl/sdf_ser.sv
rtl/sd_spi_command_framer_top.sv
test/tb_top.sv
